@@ hdl/rtlpm_pkg.sv @@
// Shared types, codes and prefix-length functions for the IPv4 route table.
`default_nettype none
package rtlpm_pkg;

	// operation codes on the input beat
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_GET    = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NONE  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [31:0] subnet;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  iface;
		logic [3:0]  metric;
	} entry_t;

	typedef enum logic [2:0] {
		KIND_ADD,
		KIND_REMOVE,
		KIND_LOOKUP,
		KIND_FIND,
		KIND_GET,
		KIND_BAD,
		KIND_RANGE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  index;
		entry_t      entry;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot;
		entry_t     entry;
		logic [5:0] plen;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_FETCH,
		ST_WAIT,
		ST_SHIFT,
		ST_SCAN,
		ST_DONE
	} state_t;

	function automatic logic [3:0] byte_prefix(input logic [7:0] b);
		logic [3:0] n;
		begin
			unique case (b)
				8'd255: n = 4'd8;
				8'd254: n = 4'd7;
				8'd252: n = 4'd6;
				8'd248: n = 4'd5;
				8'd240: n = 4'd4;
				8'd224: n = 4'd3;
				8'd192: n = 4'd2;
				8'd128: n = 4'd1;
				default: n = 4'd0;
			endcase
			return n;
		end
	endfunction

	function automatic logic [5:0] mask_prefix(input logic [31:0] m);
		return 6'(byte_prefix(m[31:24])) + 6'(byte_prefix(m[23:16])) +
			6'(byte_prefix(m[15:8])) + 6'(byte_prefix(m[7:0]));
	endfunction

endpackage
`default_nettype wire

@@ hdl/ipv4_route_table_lpm_core.sv @@
// Top level of the IPv4 route table with longest-prefix-match lookup.
// Every input beat gives exactly one result beat, in order. The front end queues
// up to two beats; the engine runs one operation at a time over a route memory with
// one read port and one write port (registered read data). Lookup and find read
// every slot once; add walks the valid bits to the first free slot, or to the end
// when the table is full; remove copies each later slot down one place; get reads
// the indexed slot; an unknown or out-of-range operation goes straight to done.
// A stalled result holds the engine in its done state.
// No clearing pass follows reset: the valid bits are cleared at once.
`default_nettype none
module ipv4_route_table_lpm_core #(
	parameter int TABLE_SIZE = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [5:0]  entry_index,
	input  wire logic [31:0] key_address,
	input  wire logic [31:0] key_mask,
	input  wire logic [31:0] gateway_addr,
	input  wire logic [3:0]  iface_id,
	input  wire logic [3:0]  route_metric,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [5:0]       slot,
	output logic [31:0]      out_subnet,
	output logic [31:0]      out_mask,
	output logic [31:0]      out_gateway,
	output logic [3:0]       out_iface,
	output logic [3:0]       out_metric,
	output logic [5:0]       prefix_len
);
	import rtlpm_pkg::*;

	logic    cmd_valid;
	logic    cmd_take;
	cmd_t    cmd;
	result_t result;

	rtlpm_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.entry_index  (entry_index),
		.key_address  (key_address),
		.key_mask     (key_mask),
		.gateway_addr (gateway_addr),
		.iface_id     (iface_id),
		.route_metric (route_metric),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	rtlpm_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	// unpack the result beat
	assign status      = result.status;
	assign slot        = result.slot;
	assign out_subnet  = result.entry.subnet;
	assign out_mask    = result.entry.mask;
	assign out_gateway = result.entry.gateway;
	assign out_iface   = result.entry.iface;
	assign out_metric  = result.entry.metric;
	assign prefix_len  = result.plen;

endmodule
`default_nettype wire

@@ hdl/rtlpm_front.sv @@
// Front end: classifies input beats and queues them for the table engine.
`default_nettype none
module rtlpm_front #(
	parameter int TABLE_SIZE = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        operation,
	input  wire logic [5:0]        entry_index,
	input  wire logic [31:0]       key_address,
	input  wire logic [31:0]       key_mask,
	input  wire logic [31:0]       gateway_addr,
	input  wire logic [3:0]        iface_id,
	input  wire logic [3:0]        route_metric,
	output logic                   cmd_valid,
	output rtlpm_pkg::cmd_t        cmd,
	input  wire logic              cmd_take
);
	import rtlpm_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;
	logic       pop;
	logic       out_of_range;

	// classify the incoming beat
	always_comb begin
		out_of_range = {1'b0, entry_index} >= 7'(TABLE_SIZE);
		cls.index = entry_index;
		cls.entry.subnet = key_address;
		cls.entry.mask = key_mask;
		cls.entry.gateway = gateway_addr;
		cls.entry.iface = iface_id;
		cls.entry.metric = route_metric;
		unique case (operation)
			OP_ADD:    cls.kind = KIND_ADD;
			OP_REMOVE: cls.kind = out_of_range ? KIND_RANGE : KIND_REMOVE;
			OP_LOOKUP: cls.kind = KIND_LOOKUP;
			OP_FIND:   cls.kind = KIND_FIND;
			OP_GET:    cls.kind = out_of_range ? KIND_RANGE : KIND_GET;
			default:   cls.kind = KIND_BAD;
		endcase
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = queue_q[rd_ptr_q];

	// store the classified beat
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// advance the queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

@@ hdl/rtlpm_back.sv @@
// Back end: route memory, valid bits and the sequencer that runs each operation.
`default_nettype none
module rtlpm_back #(
	parameter int TABLE_SIZE = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire rtlpm_pkg::cmd_t   cmd,
	output logic                   cmd_take,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rtlpm_pkg::result_t     result
);
	import rtlpm_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = IW + 1;

	entry_t              mem [TABLE_SIZE];
	entry_t              rd_data_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                rd_vld_s1;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [CW-1:0]       ptr_q;
	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [5:0]          best_len_q;
	entry_t              best_q;
	result_t             res_q;
	result_t             res_init;
	result_t             out_q;
	logic                out_valid_q;
	logic [TABLE_SIZE-1:0] valid_q;

	logic                ptr_end;
	logic                mem_re, mem_we;
	logic [IW-1:0]       mem_raddr, mem_waddr;
	entry_t              mem_wdata;
	logic                hit;
	logic                better;
	logic [5:0]          cur_len;
	logic                out_free;

	assign ptr_end  = (ptr_q == CW'(TABLE_SIZE));
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	// start each operation with an empty result
	always_comb begin
		res_init = '0;
		res_init.status = (cmd.kind == KIND_RANGE) ? STAT_RANGE : STAT_NONE;
	end

	// compare the entry read in the previous cycle
	always_comb begin
		cur_len = mask_prefix(rd_data_s1.mask);
		if (cmd_q.kind == KIND_LOOKUP) begin
			hit = valid_q[rd_idx_s1] &&
				((cmd_q.entry.subnet & rd_data_s1.mask) == rd_data_s1.subnet);
			better = hit && (!found_q || (cur_len > best_len_q));
		end else begin
			hit = valid_q[rd_idx_s1] && (rd_data_s1.subnet == cmd_q.entry.subnet) &&
				(rd_data_s1.mask == cmd_q.entry.mask);
			better = hit && !found_q;
		end
	end

	// sequence the operation: next state and memory strobes
	always_comb begin
		state_d   = state_q;
		cmd_take  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1 - IW'(1);
		mem_wdata = rd_data_s1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_take = cmd_valid;
				if (cmd_valid) begin
					unique case (cmd.kind)
						KIND_ADD:                state_d = ST_ADD;
						KIND_REMOVE, KIND_GET:   state_d = ST_FETCH;
						KIND_LOOKUP, KIND_FIND:  state_d = ST_SCAN;
						default:                 state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD: begin
				mem_waddr = ptr_q[IW-1:0];
				mem_wdata = cmd_q.entry;
				if (ptr_end) begin
					state_d = ST_DONE;
				end else if (!valid_q[ptr_q[IW-1:0]]) begin
					mem_we  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_FETCH: begin
				mem_re    = 1'b1;
				mem_raddr = cmd_q.index[IW-1:0];
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				state_d = (cmd_q.kind == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
			end
			ST_SHIFT: begin
				mem_re = !ptr_end;
				mem_we = rd_vld_s1;
				if (ptr_end && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				mem_re = !ptr_end;
				if (ptr_end && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold the route memory with a registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
		rd_idx_s1 <= mem_raddr;
	end

	// advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd;
				ptr_q   <= '0;
				found_q <= 1'b0;
				best_len_q <= '0;
				res_q   <= res_init;
			end
			ST_ADD: begin
				if (ptr_end) begin
					res_q.status <= STAT_FULL;
				end else if (!valid_q[ptr_q[IW-1:0]]) begin
					res_q.status <= STAT_OK;
					res_q.slot   <= 6'(ptr_q);
					res_q.entry  <= cmd_q.entry;
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			ST_FETCH: begin
				res_q.slot   <= cmd_q.index;
				res_q.status <= valid_q[cmd_q.index[IW-1:0]] ? STAT_OK : STAT_NONE;
			end
			ST_WAIT: begin
				if (res_q.status == STAT_OK) begin
					res_q.entry <= rd_data_s1;
				end
				ptr_q <= CW'(cmd_q.index) + CW'(1);
			end
			ST_SHIFT: begin
				if (!ptr_end) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			ST_SCAN: begin
				if (!ptr_end) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (rd_vld_s1 && better) begin
					found_q    <= 1'b1;
					best_idx_q <= rd_idx_s1;
					best_len_q <= cur_len;
					best_q     <= rd_data_s1;
				end
				if (ptr_end && !rd_vld_s1 && found_q) begin
					res_q.status <= STAT_OK;
					res_q.slot   <= 6'(best_idx_q);
					res_q.entry  <= best_q;
					res_q.plen   <= (cmd_q.kind == KIND_LOOKUP) ? best_len_q : 6'd0;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	// control flags: read tracking, valid bits, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re && (state_q == ST_SHIFT || state_q == ST_SCAN);
			if (state_q == ST_ADD && mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			// drop the removed slot and shift the later valid bits down
			if (state_q == ST_FETCH && cmd_q.kind == KIND_REMOVE) begin
				for (int i = 0; i < TABLE_SIZE; i++) begin
					if (7'(i) >= {1'b0, cmd_q.index}) begin
						valid_q[i] <= (i == TABLE_SIZE - 1) ? 1'b0 :
							valid_q[(i == TABLE_SIZE - 1) ? i : i + 1];
					end
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
